[sv/fixed_block_free_list_allocator_core_assert.svh]
// Assertion macros for the block allocator core.
// SAME checks an implication in the same cycle, NEXT in the cycle after.
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define FBFLA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator check failed");
`define FBFLA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator check failed");
`else
`define FBFLA_ASSERT_SAME(label, ante, cons)
`define FBFLA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[sv/fbfla_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package fbfla_pkg;

  // Field widths
  localparam int CMD_W      = 2;
  localparam int IN_IDX_W   = 10;
  localparam int OUT_IDX_W  = 10;
  localparam int OUT_ADDR_W = 32;
  localparam int STATUS_W   = 2;
  localparam int FREE_W     = 11;
  localparam int BCOUNT_W   = 11;
  localparam int BSIZE_W    = 17;
  localparam int BASE_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Register reset values
  localparam logic [BCOUNT_W-1:0] BLOCK_COUNT_RST  = 11'd1024;
  localparam logic [BSIZE_W-1:0]  BLOCK_SIZE_RST   = 17'd64;
  localparam logic [BASE_W-1:0]   BASE_ADDRESS_RST = 32'd0;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_REINIT = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_RANGE  = 2'd2,
    ST_REINIT = 2'd3
  } status_t;

endpackage
`default_nettype wire

[sv/fbfla_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// Request channel: one command per request
interface fbfla_req_if;
  logic                                 valid;
  logic                                 ready;
  fbfla_pkg::cmd_t                      command;
  logic [fbfla_pkg::IN_IDX_W-1:0]       block_index;

  modport source (output valid, output command, output block_index, input ready);
  modport sink   (input valid, input command, input block_index, output ready);
endinterface

// Response channel: one response per request
interface fbfla_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [fbfla_pkg::OUT_IDX_W-1:0]      granted_index;
  logic [fbfla_pkg::OUT_ADDR_W-1:0]     granted_address;
  fbfla_pkg::status_t                   status;
  logic [fbfla_pkg::FREE_W-1:0]         free_blocks;

  modport source (output valid, output granted_index, output granted_address,
                  output status, output free_blocks, input ready);
  modport sink   (input valid, input granted_index, input granted_address,
                  input status, input free_blocks, output ready);
endinterface

// Configuration write channel
interface fbfla_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [fbfla_pkg::CFG_IDX_W-1:0]      index;
  logic [fbfla_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[sv/fbfla_link_mem.sv]
`timescale 1ns / 1ps
`default_nettype none
module fbfla_link_mem #(
  parameter int DEPTH = 1024,
  parameter int DW    = 11
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write one link, read one link with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[sv/fbfla_addr_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
module fbfla_addr_unit #(
  parameter int IDX_W      = 10,
  parameter int ADDR_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [IDX_W-1:0]               idx,
  input  logic [fbfla_pkg::BSIZE_W-1:0]  block_size,
  input  logic [fbfla_pkg::BASE_W-1:0]   base_address,
  output logic [ADDR_WIDTH-1:0]          addr
);
  import fbfla_pkg::*;

  localparam int PROD_W = IDX_W + BSIZE_W;

  logic              s1_valid;
  logic [PROD_W-1:0] prod;
  logic [BASE_W-1:0] base_q;
  logic [63:0]       sum_wide;

  // Stage one: index times block size
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start;
    end
    if (start) begin
      prod   <= PROD_W'(idx) * PROD_W'(block_size);
      base_q <= base_address;
    end
  end

  assign sum_wide = 64'(base_q) + 64'(prod);

  // Stage two: add base, wrap to the address width, hold until the next start
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      addr <= sum_wide[ADDR_WIDTH-1:0];
    end
  end

endmodule
`default_nettype wire

[sv/fixed_block_free_list_allocator_core.sv]
// Fixed-size block allocator: LIFO free list of block indices in a link memory.
// After acceptance, alloc passes S_ALLOC, S_ALLOC_WAIT (link read, adder) and S_DONE,
// free passes S_FREE and S_DONE, empty alloc and no-op go straight to S_DONE, and
// reinit sweeps the n blocks in use (one link write per cycle) before S_DONE.
// A new request is taken the cycle after S_DONE registers the response, which can stall on rsp.ready.
// Reset (synchronous): rebuilds the chain over min(1024, MAX_BLOCKS) blocks, no requests.
`timescale 1ns / 1ps
`default_nettype none
`include "fixed_block_free_list_allocator_core_assert.svh"
module fixed_block_free_list_allocator_core #(
  parameter int MAX_BLOCKS = 1024,
  parameter int ADDR_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  fbfla_req_if.sink     req,
  fbfla_rsp_if.source   rsp,
  fbfla_cfg_if.sink     cfg
);
  import fbfla_pkg::*;

  localparam int IDX_W  = $clog2(MAX_BLOCKS);
  localparam int LINK_W = $clog2(MAX_BLOCKS + 1);
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_BLOCKS);
  localparam int RST_N = (int'(BLOCK_COUNT_RST) > MAX_BLOCKS) ? MAX_BLOCKS
                                                               : int'(BLOCK_COUNT_RST);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_ALLOC,
    S_ALLOC_WAIT,
    S_FREE,
    S_DONE
  } state_t;

  state_t                 state;
  logic [BCOUNT_W-1:0]    block_count;
  logic [BSIZE_W-1:0]     block_size;
  logic [BASE_W-1:0]      base_address;

  logic [LINK_W-1:0]      free_head;
  logic [LINK_W-1:0]      free_total;
  logic [LINK_W-1:0]      sweep_idx;
  logic [LINK_W-1:0]      sweep_n;
  logic                   init_reply;
  logic [IN_IDX_W-1:0]    free_idx;
  status_t                pend_status;
  logic                   pend_grant;
  logic [OUT_IDX_W-1:0]   pend_index;

  logic                   out_valid;
  logic [OUT_IDX_W-1:0]   out_index;
  logic [OUT_ADDR_W-1:0]  out_address;
  status_t                out_status;
  logic [FREE_W-1:0]      out_free;

  logic [31:0]            bc_wide;
  logic [LINK_W-1:0]      used_n;
  logic [LINK_W-1:0]      sweep_inc;
  logic [31:0]            idx_wide;
  logic [31:0]            head_wide;
  logic [31:0]            total_wide;
  logic                   free_ok;
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_waddr;
  logic [LINK_W-1:0]      mem_wdata;
  logic [LINK_W-1:0]      mem_rdata;
  logic [ADDR_WIDTH-1:0]  unit_addr;
  logic [63:0]            addr_wide;

  // Configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count  <= BLOCK_COUNT_RST;
      block_size   <= BLOCK_SIZE_RST;
      base_address <= BASE_ADDRESS_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_BLOCK_COUNT:  block_count  <= cfg.data[BCOUNT_W-1:0];
        REG_BLOCK_SIZE:   block_size   <= cfg.data[BSIZE_W-1:0];
        REG_BASE_ADDRESS: base_address <= cfg.data[BASE_W-1:0];
        default:          ;
      endcase
    end
  end

  // Clamp the block count into one to MAX_BLOCKS
  assign bc_wide = 32'(block_count);
  assign used_n  = (bc_wide == 32'd0) ? LINK_W'(1)
                 : (bc_wide > 32'(MAX_BLOCKS)) ? NULL_LINK
                 : LINK_W'(bc_wide);

  assign sweep_inc  = sweep_idx + LINK_W'(1);
  assign idx_wide   = 32'(free_idx);
  assign head_wide  = 32'(free_head);
  assign total_wide = 32'(free_total);
  assign free_ok    = idx_wide < 32'(used_n);

  // Link memory writes: chain during the sweep, push on free
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep_idx[IDX_W-1:0];
    mem_wdata = (sweep_inc < sweep_n) ? sweep_inc : NULL_LINK;
    if (state == S_INIT) begin
      mem_we = 1'b1;
    end else if (state == S_FREE) begin
      mem_we    = free_ok;
      mem_waddr = idx_wide[IDX_W-1:0];
      mem_wdata = free_head;
    end
  end

  fbfla_link_mem #(
    .DEPTH (MAX_BLOCKS),
    .DW    (LINK_W)
  ) u_link_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (free_head[IDX_W-1:0]),
    .rdata (mem_rdata)
  );

  fbfla_addr_unit #(
    .IDX_W      (IDX_W),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_addr_unit (
    .clk          (clk),
    .rst          (rst),
    .start        (state == S_ALLOC),
    .idx          (free_head[IDX_W-1:0]),
    .block_size   (block_size),
    .base_address (base_address),
    .addr         (unit_addr)
  );

  assign addr_wide = 64'(unit_addr);

  // Sequencer: sweep, accept, pop or push, then register the response
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      sweep_idx  <= '0;
      sweep_n    <= LINK_W'(RST_N);
      init_reply <= 1'b0;
      free_head  <= '0;
      free_total <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          sweep_idx <= sweep_inc;
          if (sweep_inc >= sweep_n) begin
            free_head   <= '0;
            free_total  <= sweep_n;
            pend_status <= ST_REINIT;
            pend_grant  <= 1'b0;
            state       <= init_reply ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            free_idx   <= req.block_index;
            pend_grant <= 1'b0;
            unique case (req.command)
              CMD_ALLOC: begin
                if (free_head >= NULL_LINK) begin
                  pend_status <= ST_EMPTY;
                  state       <= S_DONE;
                end else begin
                  state <= S_ALLOC;
                end
              end
              CMD_FREE: begin
                state <= S_FREE;
              end
              CMD_REINIT: begin
                sweep_idx  <= '0;
                sweep_n    <= used_n;
                init_reply <= 1'b1;
                state      <= S_INIT;
              end
              CMD_NOP: begin
                pend_status <= ST_OK;
                state       <= S_DONE;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_ALLOC: begin
          state <= S_ALLOC_WAIT;
        end
        S_ALLOC_WAIT: begin
          // Pop the head, read data is the next free block
          free_head   <= mem_rdata;
          pend_index  <= head_wide[OUT_IDX_W-1:0];
          pend_grant  <= 1'b1;
          pend_status <= ST_OK;
          if (free_total != '0) begin
            free_total <= free_total - LINK_W'(1);
          end
          state <= S_DONE;
        end
        S_FREE: begin
          if (free_ok) begin
            free_head   <= idx_wide[LINK_W-1:0];
            pend_status <= ST_OK;
            if (free_total < used_n) begin
              free_total <= free_total + LINK_W'(1);
            end
          end else begin
            pend_status <= ST_RANGE;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid   <= 1'b1;
            out_index   <= pend_grant ? pend_index : '0;
            out_address <= pend_grant ? addr_wide[OUT_ADDR_W-1:0] : '0;
            out_status  <= pend_status;
            out_free    <= total_wide[FREE_W-1:0];
            init_reply  <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready           = (state == S_IDLE);
  assign rsp.valid           = out_valid;
  assign rsp.granted_index   = out_index;
  assign rsp.granted_address = out_address;
  assign rsp.status          = out_status;
  assign rsp.free_blocks     = out_free;

  // An empty list never counts free blocks
  `FBFLA_ASSERT_SAME(a_empty_count, free_head == NULL_LINK, free_total == '0)
  // No request is taken while the chain is rebuilt
  `FBFLA_ASSERT_SAME(a_init_busy, state == S_INIT, !req.ready)
  // A pop always follows the link read in the next cycle
  `FBFLA_ASSERT_NEXT(a_alloc_seq, state == S_ALLOC, state == S_ALLOC_WAIT)

endmodule
`default_nettype wire
